@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// expression must never be true at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ hdl/ssprk_pkg.sv @@
// ----------------------------------------------------------------------------
// ssprk_pkg
// Types, widths and constants of the SSP Runge-Kutta stage update pipeline.
// ----------------------------------------------------------------------------
package ssprk_pkg;

    localparam int VAL_W  = 32;            // Q16.16 word
    localparam int NUM_W  = 64;            // dt * |R| + vol/2
    localparam int QUO_W  = 41;            // quotient bits kept, clip at 2^40
    localparam int DIFF_W = QUO_W + 1;     // signed step term
    localparam int WGT_W  = 17;            // Q16.16 weight, up to 1.0
    localparam int PA_W   = WGT_W + 1 + VAL_W;
    localparam int PC_W   = WGT_W + 1 + DIFF_W;
    localparam int ACC_W  = 61;
    localparam int FRAC_W = 16;
    localparam int RES_W  = ACC_W - FRAC_W;

    localparam int FRONT_STAGES = 3;
    localparam int DIV_STAGES   = QUO_W;
    localparam int BLEND_STAGES = 4;
    localparam int PIPE_LATENCY = FRONT_STAGES + DIV_STAGES + BLEND_STAGES;

    typedef logic [2:0]              stage_t;
    typedef logic signed [VAL_W-1:0] val_t;

    localparam stage_t STAGE_SAVE    = 3'd0;
    localparam stage_t STAGE_EULER   = 3'd1;
    localparam stage_t STAGE_RK3_MID = 3'd2;
    localparam stage_t STAGE_RK3_END = 3'd3;
    localparam stage_t STAGE_RK2_END = 3'd4;

    localparam logic [WGT_W-1:0] W_ONE = 17'd65536;
    localparam logic [WGT_W-1:0] W_3_4 = 17'd49152;
    localparam logic [WGT_W-1:0] W_1_4 = 17'd16384;
    localparam logic [WGT_W-1:0] W_1_3 = 17'd21845;
    localparam logic [WGT_W-1:0] W_2_3 = 17'd43691;
    localparam logic [WGT_W-1:0] W_1_2 = 17'd32768;
    localparam logic [WGT_W-1:0] W_NIL = 17'd0;

    localparam logic [QUO_W-1:0]        D_LIMIT    = 41'h100_0000_0000;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 61'sd32768;
    localparam val_t                    VAL_MAX    = 32'sh7FFF_FFFF;
    localparam val_t                    VAL_MIN    = 32'sh8000_0000;

    typedef struct packed {
        stage_t stage;
        val_t   cur;
        val_t   saved;
        logic   last;
        logic   neg;
    } ssprk_side_t;

    typedef struct packed {
        logic [WGT_W-1:0] a;
        logic [WGT_W-1:0] b;
        logic [WGT_W-1:0] c;
    } ssprk_wgt_t;

    typedef struct packed {
        val_t new_value;
        val_t new_saved;
        logic saturated;
        logic last;
    } ssprk_result_t;

    // weights (a, b, c) of acc = a*SN + b*S - c*d
    function automatic ssprk_wgt_t stage_weights(input stage_t st);
        ssprk_wgt_t w;
        unique case (st)
            STAGE_EULER:   w = '{a: W_ONE, b: W_NIL, c: W_ONE};
            STAGE_RK3_MID: w = '{a: W_3_4, b: W_1_4, c: W_1_4};
            STAGE_RK3_END: w = '{a: W_1_3, b: W_2_3, c: W_2_3};
            default:       w = '{a: W_1_2, b: W_1_2, c: W_1_2};
        endcase
        return w;
    endfunction

endpackage

@@ hdl/ssprk_front.sv @@
// ----------------------------------------------------------------------------
// ssprk_front
// Input capture, residual magnitude, dt * |R| product and rounding bias.
// ----------------------------------------------------------------------------
module ssprk_front
    import ssprk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  stage_t            stage,
    input  logic [VAL_W-1:0]  current_value,
    input  logic [VAL_W-1:0]  saved_value,
    input  logic [VAL_W-1:0]  residual,
    input  logic [VAL_W-1:0]  cell_volume,
    input  logic              last_in_cell,
    input  logic [VAL_W-1:0]  time_step,
    output logic              out_valid,
    output ssprk_side_t       out_side,
    output logic [NUM_W-1:0]  out_num,
    output logic [VAL_W-1:0]  out_vol
);

    logic              a_valid_reg;
    ssprk_side_t       a_side_reg;
    ssprk_side_t       a_side_next;
    logic [VAL_W-1:0]  a_mag_reg;
    logic [VAL_W-1:0]  a_mag_next;
    logic [VAL_W-1:0]  a_vol_reg;
    logic [VAL_W-1:0]  a_vol_next;

    logic              b_valid_reg;
    ssprk_side_t       b_side_reg;
    logic [NUM_W-1:0]  b_prod_reg;
    logic [NUM_W-1:0]  b_prod_next;
    logic [VAL_W-1:0]  b_vol_reg;

    logic              c_valid_reg;
    ssprk_side_t       c_side_reg;
    logic [NUM_W-1:0]  c_num_reg;
    logic [NUM_W-1:0]  c_num_next;
    logic [VAL_W-1:0]  c_vol_reg;

    always_comb
    begin
        a_side_next.stage = stage;
        a_side_next.cur   = $signed(current_value);
        a_side_next.saved = $signed(saved_value);
        a_side_next.last  = last_in_cell;
        a_side_next.neg   = residual[VAL_W-1];
        a_mag_next  = residual[VAL_W-1] ? (~residual + 32'd1) : residual;
        a_vol_next  = (cell_volume == '0) ? 32'd1 : cell_volume;
        b_prod_next = NUM_W'(time_step) * NUM_W'(a_mag_reg);
        c_num_next  = b_prod_reg + NUM_W'(b_vol_reg >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg <= a_side_next;
        a_mag_reg  <= a_mag_next;
        a_vol_reg  <= a_vol_next;
        b_side_reg <= a_side_reg;
        b_prod_reg <= b_prod_next;
        b_vol_reg  <= a_vol_reg;
        c_side_reg <= b_side_reg;
        c_num_reg  <= c_num_next;
        c_vol_reg  <= b_vol_reg;
    end

    assign out_valid = c_valid_reg;
    assign out_side  = c_side_reg;
    assign out_num   = c_num_reg;
    assign out_vol   = c_vol_reg;

endmodule

@@ hdl/ssprk_div.sv @@
// ----------------------------------------------------------------------------
// ssprk_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detect for quotients of 2^41 and above.
// ----------------------------------------------------------------------------
module ssprk_div
    import ssprk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ssprk_side_t       in_side,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [VAL_W-1:0]  in_vol,
    output logic              out_valid,
    output ssprk_side_t       out_side,
    output logic [QUO_W-1:0]  out_quo,
    output logic              out_ovf
);

    logic              valid_reg [DIV_STAGES];
    logic              valid_next[DIV_STAGES];
    ssprk_side_t       side_reg  [DIV_STAGES];
    ssprk_side_t       side_next [DIV_STAGES];
    logic [VAL_W-1:0]  rem_reg   [DIV_STAGES];
    logic [VAL_W-1:0]  rem_next  [DIV_STAGES];
    logic [QUO_W-1:0]  low_reg   [DIV_STAGES];
    logic [QUO_W-1:0]  low_next  [DIV_STAGES];
    logic [QUO_W-1:0]  quo_reg   [DIV_STAGES];
    logic [QUO_W-1:0]  quo_next  [DIV_STAGES];
    logic [VAL_W-1:0]  vol_reg   [DIV_STAGES];
    logic [VAL_W-1:0]  vol_next  [DIV_STAGES];
    logic              ovf_reg   [DIV_STAGES];
    logic              ovf_next  [DIV_STAGES];

    always_comb
    begin
        logic             p_valid;
        ssprk_side_t      p_side;
        logic [VAL_W-1:0] p_rem;
        logic [QUO_W-1:0] p_low;
        logic [QUO_W-1:0] p_quo;
        logic [VAL_W-1:0] p_vol;
        logic             p_ovf;
        logic [VAL_W:0]   trial;
        logic             ge;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                p_valid = in_valid;
                p_side  = in_side;
                p_rem   = VAL_W'(in_num[NUM_W-1:QUO_W]);
                p_low   = in_num[QUO_W-1:0];
                p_quo   = '0;
                p_vol   = in_vol;
                p_ovf   = (VAL_W'(in_num[NUM_W-1:QUO_W]) >= in_vol);
            end
            else
            begin
                p_valid = valid_reg[k-1];
                p_side  = side_reg[k-1];
                p_rem   = rem_reg[k-1];
                p_low   = low_reg[k-1];
                p_quo   = quo_reg[k-1];
                p_vol   = vol_reg[k-1];
                p_ovf   = ovf_reg[k-1];
            end
            trial = {p_rem, p_low[QUO_W-1-k]};
            ge    = (trial >= {1'b0, p_vol});
            valid_next[k] = p_valid;
            side_next[k]  = p_side;
            rem_next[k]   = ge ? VAL_W'(trial - {1'b0, p_vol}) : VAL_W'(trial);
            low_next[k]   = p_low;
            quo_next[k]   = p_quo;
            quo_next[k][QUO_W-1-k] = ge;
            vol_next[k]   = p_vol;
            ovf_next[k]   = p_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            side_reg[k] <= side_next[k];
            rem_reg[k]  <= rem_next[k];
            low_reg[k]  <= low_next[k];
            quo_reg[k]  <= quo_next[k];
            vol_reg[k]  <= vol_next[k];
            ovf_reg[k]  <= ovf_next[k];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
    assign out_quo   = quo_reg[DIV_STAGES-1];
    assign out_ovf   = ovf_reg[DIV_STAGES-1];

endmodule

@@ hdl/ssprk_blend.sv @@
// ----------------------------------------------------------------------------
// ssprk_blend
// Step term clip and sign, stage weighting, accumulate, round and saturate.
// ----------------------------------------------------------------------------
module ssprk_blend
    import ssprk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ssprk_side_t       in_side,
    input  logic [QUO_W-1:0]  in_quo,
    input  logic              in_ovf,
    output logic              out_valid,
    output ssprk_result_t     out_result
);

    // E: signed step term and weights
    logic                      e_valid_reg;
    ssprk_side_t               e_side_reg;
    logic signed [DIFF_W-1:0]  e_d_reg;
    logic signed [DIFF_W-1:0]  e_d_next;
    ssprk_wgt_t                e_wgt_reg;
    ssprk_wgt_t                e_wgt_next;

    // F: products
    logic                      f_valid_reg;
    ssprk_side_t               f_side_reg;
    logic signed [PA_W-1:0]    f_pa_reg;
    logic signed [PA_W-1:0]    f_pa_next;
    logic signed [PA_W-1:0]    f_pb_reg;
    logic signed [PA_W-1:0]    f_pb_next;
    logic signed [PC_W-1:0]    f_pc_reg;
    logic signed [PC_W-1:0]    f_pc_next;

    // G: accumulator
    logic                      g_valid_reg;
    ssprk_side_t               g_side_reg;
    logic signed [ACC_W-1:0]   g_acc_reg;
    logic signed [ACC_W-1:0]   g_acc_next;

    // H: result
    logic                      h_valid_reg;
    ssprk_result_t             h_result_reg;
    ssprk_result_t             h_result_next;

    logic [QUO_W-1:0]          quo_clip;
    logic [DIFF_W-1:0]         d_mag;
    logic signed [ACC_W-1:0]   rnd;
    logic signed [RES_W-1:0]   res;
    logic [RES_W-VAL_W:0]      res_hi;
    logic                      pos_ovf;
    logic                      neg_ovf;
    val_t                      res_sat;

    always_comb
    begin
        quo_clip   = (in_ovf || (in_quo > D_LIMIT)) ? D_LIMIT : in_quo;
        d_mag      = {1'b0, quo_clip};
        e_d_next   = in_side.neg ? $signed(~d_mag + 1'b1) : $signed(d_mag);
        e_wgt_next = stage_weights(in_side.stage);
    end

    always_comb
    begin
        f_pa_next = $signed({1'b0, e_wgt_reg.a}) * $signed(e_side_reg.saved);
        f_pb_next = $signed({1'b0, e_wgt_reg.b}) * $signed(e_side_reg.cur);
        f_pc_next = $signed({1'b0, e_wgt_reg.c}) * e_d_reg;
    end

    assign g_acc_next = ACC_W'(f_pa_reg) + ACC_W'(f_pb_reg) - ACC_W'(f_pc_reg);

    // round half up, then clip to 32 bits
    always_comb
    begin
        rnd     = g_acc_reg + ROUND_HALF;
        res     = $signed(rnd[ACC_W-1:FRAC_W]);
        res_hi  = res[RES_W-1:VAL_W-1];
        pos_ovf = !res[RES_W-1] && (|res_hi);
        neg_ovf =  res[RES_W-1] && !(&res_hi);
        if (pos_ovf)
        begin
            res_sat = VAL_MAX;
        end
        else if (neg_ovf)
        begin
            res_sat = VAL_MIN;
        end
        else
        begin
            res_sat = $signed(res[VAL_W-1:0]);
        end

        h_result_next.last = g_side_reg.last;
        case (g_side_reg.stage) inside
            STAGE_SAVE:
            begin
                h_result_next.new_value = g_side_reg.cur;
                h_result_next.new_saved = g_side_reg.cur;
                h_result_next.saturated = 1'b0;
            end
            STAGE_EULER, STAGE_RK3_MID, STAGE_RK3_END, STAGE_RK2_END:
            begin
                h_result_next.new_value = res_sat;
                h_result_next.new_saved = g_side_reg.saved;
                h_result_next.saturated = pos_ovf || neg_ovf;
            end
            default:
            begin
                h_result_next.new_value = g_side_reg.cur;
                h_result_next.new_saved = g_side_reg.saved;
                h_result_next.saturated = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= in_valid;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_side_reg   <= in_side;
        e_d_reg      <= e_d_next;
        e_wgt_reg    <= e_wgt_next;
        f_side_reg   <= e_side_reg;
        f_pa_reg     <= f_pa_next;
        f_pb_reg     <= f_pb_next;
        f_pc_reg     <= f_pc_next;
        g_side_reg   <= f_side_reg;
        g_acc_reg    <= g_acc_next;
        h_result_reg <= h_result_next;
    end

    assign out_valid  = h_valid_reg;
    assign out_result = h_result_reg;

endmodule

@@ hdl/ssp_runge_kutta_stage_update.sv @@
// ----------------------------------------------------------------------------
// ssp_runge_kutta_stage_update
// Shu-Osher SSP Runge-Kutta stage update of one Q16.16 solution component:
// save, forward Euler, RK3 and RK2 blends with d = dt * R / V.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   item in  | start / busy           | stage, current_value, saved_value,
//            |                        | residual, cell_volume, last_in_cell
//   result   | done (one-cycle pulse) | new_value, new_saved_value,
//            |                        | saturated, last_out
//   config   | cfg_valid / cfg_ready  | cfg_data (time_step)
//
// One beat accepted per cycle; busy is never raised.
// The pipeline has 3 front stages (capture, 32x32 multiply, bias add),
// 41 divider stages at one quotient bit each and 4 blend stages.
// Reset clears all valid bits and time_step; no clearing pass.
// Results cannot be stalled, so the pipeline never holds.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssp_runge_kutta_stage_update
    import ssprk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  stage_t            stage,
    input  logic [VAL_W-1:0]  current_value,
    input  logic [VAL_W-1:0]  saved_value,
    input  logic [VAL_W-1:0]  residual,
    input  logic [VAL_W-1:0]  cell_volume,
    input  logic              last_in_cell,
    output logic              done,
    output logic [VAL_W-1:0]  new_value,
    output logic [VAL_W-1:0]  new_saved_value,
    output logic              saturated,
    output logic              last_out,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [VAL_W-1:0]  cfg_data
);

    logic [VAL_W-1:0]  time_step_reg;

    logic              front_valid;
    ssprk_side_t       front_side;
    logic [NUM_W-1:0]  front_num;
    logic [VAL_W-1:0]  front_vol;

    logic              div_valid;
    ssprk_side_t       div_side;
    logic [QUO_W-1:0]  div_quo;
    logic              div_ovf;

    logic              blend_valid;
    ssprk_result_t     blend_result;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            time_step_reg <= cfg_data;
        end
    end

    ssprk_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (start && !busy),
        .stage         (stage),
        .current_value (current_value),
        .saved_value   (saved_value),
        .residual      (residual),
        .cell_volume   (cell_volume),
        .last_in_cell  (last_in_cell),
        .time_step     (time_step_reg),
        .out_valid     (front_valid),
        .out_side      (front_side),
        .out_num       (front_num),
        .out_vol       (front_vol)
    );

    ssprk_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_side   (front_side),
        .in_num    (front_num),
        .in_vol    (front_vol),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_quo   (div_quo),
        .out_ovf   (div_ovf)
    );

    ssprk_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_side    (div_side),
        .in_quo     (div_quo),
        .in_ovf     (div_ovf),
        .out_valid  (blend_valid),
        .out_result (blend_result)
    );

    assign done            = blend_valid;
    assign new_value       = blend_result.new_value;
    assign new_saved_value = blend_result.new_saved;
    assign saturated       = blend_result.saturated;
    assign last_out        = blend_result.last;

    `ASSERT_ALWAYS(a_done_latency, clk, rst_n, done |-> $past(start, PIPE_LATENCY),
                   "result beat without a matching input beat")
    `ASSERT_ALWAYS(a_div_latency, clk, rst_n, div_valid |-> $past(front_valid, DIV_STAGES),
                   "divider valid out of step with its input")
    `ASSERT_NEVER(a_sat_value, clk, rst_n,
                  done && saturated && new_value != VAL_MAX && new_value != VAL_MIN,
                  "saturation flag with an unclipped value")

endmodule

@@ bench/ssp_runge_kutta_stage_update_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssp_runge_kutta_stage_update_checker
// Watches the item, result and time-step channels of the stage update block.
// Works out each expected stage update when an item beat is taken, queues it
// in order and compares each result beat field by field with the oldest.
// ----------------------------------------------------------------------------
module ssp_runge_kutta_stage_update_checker
    import ssprk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  stage_t           stage,
    input  logic [VAL_W-1:0] current_value,
    input  logic [VAL_W-1:0] saved_value,
    input  logic [VAL_W-1:0] residual,
    input  logic [VAL_W-1:0] cell_volume,
    input  logic             last_in_cell,
    input  logic             done,
    input  logic [VAL_W-1:0] new_value,
    input  logic [VAL_W-1:0] new_saved_value,
    input  logic             saturated,
    input  logic             last_out,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [VAL_W-1:0] cfg_data,
    output int               failures,
    output int               pending,
    output int               checked,
    output int               clipped
);

    ssprk_result_t    stage_updates_due[$];
    logic [VAL_W-1:0] dt_q;

    initial
    begin
        failures = 0;
        pending  = 0;
        checked  = 0;
        clipped  = 0;
        dt_q     = '0;
    end

    // acc = a*SN + b*S - c*d, d = dt*R/V rounded half away from zero
    function automatic ssprk_result_t predict_update(input logic [VAL_W-1:0] dt,
                                                     input stage_t st,
                                                     input val_t cur,
                                                     input val_t sav,
                                                     input val_t res,
                                                     input logic [VAL_W-1:0] vol,
                                                     input logic last);
        ssprk_result_t upd;
        logic [63:0]   mag;
        logic [63:0]   prod;
        logic [63:0]   divisor;
        logic [63:0]   quot;
        longint        wa;
        longint        wb;
        longint        wc;
        longint        d;
        longint        acc;
        longint        rounded;
        logic          neg;
        upd.new_value = cur;
        upd.new_saved = sav;
        upd.saturated = 1'b0;
        upd.last      = last;
        wa = 0;
        wb = 0;
        wc = 0;
        case (st)
            STAGE_SAVE:
            begin
                upd.new_saved = cur;
                return upd;
            end
            STAGE_EULER:
            begin
                wa = W_ONE;
                wb = W_NIL;
                wc = W_ONE;
            end
            STAGE_RK3_MID:
            begin
                wa = W_3_4;
                wb = W_1_4;
                wc = W_1_4;
            end
            STAGE_RK3_END:
            begin
                wa = W_1_3;
                wb = W_2_3;
                wc = W_2_3;
            end
            STAGE_RK2_END:
            begin
                wa = W_1_2;
                wb = W_1_2;
                wc = W_1_2;
            end
            default:
                return upd;
        endcase
        neg     = res[VAL_W-1];
        mag     = neg ? 64'(-longint'(res)) : 64'(longint'(res));
        prod    = {32'd0, dt} * mag;
        divisor = (vol == '0) ? 64'd1 : {32'd0, vol};
        quot    = (prod + (divisor >> 1)) / divisor;
        if (quot > 64'(D_LIMIT))
            quot = 64'(D_LIMIT);
        d       = neg ? -$signed(quot) : $signed(quot);
        acc     = wa * longint'(sav) + wb * longint'(cur) - wc * d;
        rounded = (acc + 32768) >>> FRAC_W;
        if (rounded > longint'(VAL_MAX))
        begin
            rounded       = longint'(VAL_MAX);
            upd.saturated = 1'b1;
        end
        else if (rounded < longint'(VAL_MIN))
        begin
            rounded       = longint'(VAL_MIN);
            upd.saturated = 1'b1;
        end
        upd.new_value = val_t'(rounded);
        return upd;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ssprk_result_t want;
        if (!rst_n)
        begin
            dt_q = '0;
            stage_updates_due.delete();
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (stage_updates_due.size() == 0)
                begin
                    $display("%0t: result beat with nothing outstanding, expected none, got %h",
                             $time, new_value);
                    failures++;
                end
                else
                begin
                    want = stage_updates_due.pop_front();
                    check_field("new_value", want.new_value, new_value);
                    check_field("new_saved_value", want.new_saved, new_saved_value);
                    check_field("saturated", 32'(want.saturated), 32'(saturated));
                    check_field("last_out", 32'(want.last), 32'(last_out));
                    checked++;
                    if (want.saturated)
                        clipped++;
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                stage_updates_due.push_back(predict_update(dt_q, stage, current_value,
                                                           saved_value, residual,
                                                           cell_volume, last_in_cell));
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                dt_q = cfg_data;
        end
        pending = stage_updates_due.size();
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the SSP Runge-Kutta stage update block: a directed set of
// edge cases, then random cell sweeps under several time steps, sent in
// bursts with random gaps. The checker beside the block judges each result.
// ----------------------------------------------------------------------------
module testbench;
    import ssprk_pkg::*;

    localparam int     CYCLE_LIMIT      = 200000;
    localparam int     ITEMS_PER_PHASE  = 100;
    localparam int     NUM_PHASES       = 8;
    localparam int     SETTLE_CYCLES    = PIPE_LATENCY + 16;
    localparam stage_t STAGE_HOLD_FIRST = 3'd5;
    localparam stage_t STAGE_HOLD_LAST  = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    stage_t           stage;
    logic [VAL_W-1:0] current_value;
    logic [VAL_W-1:0] saved_value;
    logic [VAL_W-1:0] residual;
    logic [VAL_W-1:0] cell_volume;
    logic             last_in_cell;
    logic             done;
    logic [VAL_W-1:0] new_value;
    logic [VAL_W-1:0] new_saved_value;
    logic             saturated;
    logic             last_out;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [VAL_W-1:0] cfg_data;

    int               failures;
    int               pending;
    int               checked;
    int               clipped;
    int               cycles = 0;
    int               settings_used = 1;
    logic [VAL_W-1:0] dt_plan [NUM_PHASES];

    ssp_runge_kutta_stage_update u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .stage           (stage),
        .current_value   (current_value),
        .saved_value     (saved_value),
        .residual        (residual),
        .cell_volume     (cell_volume),
        .last_in_cell    (last_in_cell),
        .done            (done),
        .new_value       (new_value),
        .new_saved_value (new_saved_value),
        .saturated       (saturated),
        .last_out        (last_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    ssp_runge_kutta_stage_update_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .stage           (stage),
        .current_value   (current_value),
        .saved_value     (saved_value),
        .residual        (residual),
        .cell_volume     (cell_volume),
        .last_in_cell    (last_in_cell),
        .done            (done),
        .new_value       (new_value),
        .new_saved_value (new_saved_value),
        .saturated       (saturated),
        .last_out        (last_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .pending         (pending),
        .checked         (checked),
        .clipped         (clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles", cycles);
            $display("[ssp_runge_kutta_stage_update] ERROR");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2, 3:    v = $urandom;
            4, 5:
            begin
                v = $urandom_range(0, 32'h0064_0000);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            6:       v = 32'($urandom_range(0, 3)) - 32'd1;
            default: v = $signed($urandom) >>> $urandom_range(0, 24);
        endcase
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] pick_volume();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = 32'd1;
            2:       v = 32'hFFFF_FFFF;
            3, 4:    v = $urandom_range(32'h0000_4000, 32'h0004_0000);
            5:       v = $urandom_range(1, 255);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic stage_t pick_stage();
        if ($urandom_range(0, 7) == 0)
            return stage_t'($urandom_range(STAGE_HOLD_FIRST, STAGE_HOLD_LAST));
        return stage_t'($urandom_range(STAGE_SAVE, STAGE_RK2_END));
    endfunction

    // one item beat; returns on the edge that takes it
    task automatic send_item(input stage_t st, input logic [VAL_W-1:0] cur,
                             input logic [VAL_W-1:0] sav, input logic [VAL_W-1:0] res,
                             input logic [VAL_W-1:0] vol, input logic last);
        start         <= 1'b1;
        stage         <= st;
        current_value <= cur;
        saved_value   <= sav;
        residual      <= res;
        cell_volume   <= vol;
        last_in_cell  <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // idle gap with junk on the payload
    task automatic pause_input(input int n);
        start         <= 1'b0;
        stage         <= stage_t'($urandom);
        current_value <= $urandom;
        saved_value   <= $urandom;
        residual      <= $urandom;
        cell_volume   <= $urandom;
        last_in_cell  <= 1'($urandom);
        repeat (n)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_time_step(input logic [VAL_W-1:0] dt);
        cfg_valid <= 1'b1;
        cfg_data  <= dt;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_directed();
        // time step still at its reset value: no step term
        send_item(STAGE_EULER, 32'd5, 32'h0001_8000, 32'h7FFF_FFFF, 32'd1, 1'b0);
        send_item(STAGE_RK3_END, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b1);
        wait_idle();
        write_time_step(32'h0001_0000);
        send_item(STAGE_SAVE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'd3, 1'b0);
        send_item(STAGE_SAVE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  1'b1);
        send_item(STAGE_EULER, 32'd0, 32'h0010_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_item(STAGE_RK3_MID, 32'h0004_0000, 32'h0008_0000, 32'hFFFE_0000,
                  32'h0000_8000, 1'b0);
        send_item(STAGE_RK3_END, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_0003,
                  32'h0000_0002, 1'b0);
        send_item(STAGE_RK2_END, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'd1, 1'b0);
        send_item(STAGE_RK2_END, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'd1, 1'b1);
        send_item(stage_t'(3'd5), 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b0);
        send_item(stage_t'(3'd6), 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b1);
        send_item(STAGE_HOLD_LAST, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                  32'hFFFF_FFFF, 1'b0);
        // zero volume behaves as the smallest volume
        send_item(STAGE_EULER, 32'd0, 32'd0, 32'h0000_0001, 32'd0, 1'b0);
        send_item(STAGE_EULER, 32'd0, 32'd100, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        send_item(STAGE_EULER, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b0);
        send_item(STAGE_EULER, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b0);
        send_item(STAGE_RK3_END, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd1, 1'b0);
        send_item(STAGE_RK2_END, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1, 1'b1);
        send_item(STAGE_EULER, 32'd0, 32'd0, 32'h0000_0001, 32'h0000_0002, 1'b0);
        wait_idle();
        write_time_step(32'hFFFF_FFFF);
        send_item(STAGE_EULER, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd1, 1'b0);
        send_item(STAGE_EULER, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 1'b1);
        send_item(STAGE_RK3_MID, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                  1'b0);
        send_item(STAGE_RK2_END, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000,
                  1'b1);
        wait_idle();
    endtask

    // sweeps over cells of a few components, stage held for a run of cells
    task automatic run_random(input int count);
        int     burst;
        int     cell_left;
        stage_t sweep;
        logic   last;
        burst     = 0;
        cell_left = 0;
        sweep     = pick_stage();
        for (int i = 0; i < count; i++)
        begin
            if (cell_left == 0)
            begin
                cell_left = $urandom_range(1, 5);
                if ($urandom_range(0, 3) == 0)
                    sweep = pick_stage();
            end
            cell_left--;
            last = (cell_left == 0);
            if ($urandom_range(0, 15) == 0)
                last = ~last;
            send_item(($urandom_range(0, 9) == 0) ? pick_stage() : sweep, pick_value(),
                      pick_value(), pick_value(), pick_volume(), last);
            if (burst == 0)
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
            burst--;
            if (burst == 0 && i != count - 1)
                pause_input($urandom_range(1, 9));
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        stage         <= STAGE_SAVE;
        current_value <= '0;
        saved_value   <= '0;
        residual      <= '0;
        cell_volume   <= '0;
        last_in_cell  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        dt_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000,
                    32'h0000_0800, $urandom, 32'h0100_0000, $urandom};
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_time_step(dt_plan[p]);
            run_random(ITEMS_PER_PHASE);
            wait_idle();
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
        $display("Checked %0d stage updates, %0d of them clipped, over %0d time-step settings",
                 checked, clipped, settings_used);
        if (failures == 0 && pending == 0)
            $display("[ssp_runge_kutta_stage_update] OK");
        else
            $display("[ssp_runge_kutta_stage_update] ERROR");
        $finish;
    end

endmodule
